@@ rtl/core/tsas_pkg.sv @@
// shared constants and control types for the touch sample averaging block
package tsas_pkg;

    localparam int SAMPLES_DEFAULT = 16;
    localparam int SAMPLE_W        = 16;
    localparam int POS_W           = 12;
    localparam int PROD_W          = SAMPLE_W + POS_W;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int REG_IDX_W       = 3;

    localparam logic [REG_IDX_W-1:0] REG_RAW_X_MIN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RAW_X_MAX     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RAW_Y_MIN     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RAW_Y_MAX     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

    localparam logic [SAMPLE_W-1:0] RAW_MIN_RESET       = 16'd0;
    localparam logic [SAMPLE_W-1:0] RAW_MAX_RESET       = 16'hFFFF;
    localparam logic [POS_W-1:0]    SCREEN_WIDTH_RESET  = 12'd320;
    localparam logic [POS_W-1:0]    SCREEN_HEIGHT_RESET = 12'd240;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accum;     // add the accepted sample pair
        logic clear_up;  // pen lifted: clear run, load a not-touched result
        logic div_start; // launch both divider lanes
        logic div_avg;   // form the averages by reciprocal multiplication
        logic cap_avg;   // clamp the averages and take the offsets
        logic mul;       // offset times screen size
        logic load_fin;  // load the touched result, clear the run
    } tsas_cmd_t;

    typedef struct packed {
        logic last;      // next accumulated pair completes the run
        logic div_done;  // divider lanes finished this cycle
    } tsas_status_t;

endpackage

@@ rtl/core/tsas_div.sv @@
// unsigned restoring divider, one quotient bit per cycle
module tsas_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/core/tsas_datapath.sv @@
// accumulators, clamp, scale multipliers and divider lanes for both axes
module tsas_datapath #(
    parameter int SAMPLES = tsas_pkg::SAMPLES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsas_pkg::tsas_cmd_t           cmd,
    output tsas_pkg::tsas_status_t        status,
    input  logic [tsas_pkg::SAMPLE_W-1:0] sample_x,
    input  logic [tsas_pkg::SAMPLE_W-1:0] sample_y,
    input  logic [tsas_pkg::SAMPLE_W-1:0] raw_x_min,
    input  logic [tsas_pkg::SAMPLE_W-1:0] raw_x_max,
    input  logic [tsas_pkg::SAMPLE_W-1:0] raw_y_min,
    input  logic [tsas_pkg::SAMPLE_W-1:0] raw_y_max,
    input  logic [tsas_pkg::POS_W-1:0]    screen_width,
    input  logic [tsas_pkg::POS_W-1:0]    screen_height,
    output logic                          touched,
    output logic [tsas_pkg::POS_W-1:0]    pos_x,
    output logic [tsas_pkg::POS_W-1:0]    pos_y
);

    import tsas_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);
    localparam int CNT_W = $clog2(SAMPLES);

    // average by a constant: multiply by the rounded-up reciprocal, then shift;
    // exact for every sum below 2**SUM_W
    localparam int RCP_SH = SUM_W + $clog2(SAMPLES);
    localparam int RCP_W  = SUM_W + 1;
    localparam int RCP_PW = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_MUL =
        RCP_W'(((64'd1 << RCP_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    logic [SUM_W-1:0]    sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]    sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] avg_x_reg, avg_y_reg;
    logic [SAMPLE_W-1:0] diff_x_reg, diff_y_reg;
    logic [PROD_W-1:0]   prod_x_reg, prod_y_reg;
    logic                touched_reg;
    logic [POS_W-1:0]    pos_x_reg, pos_y_reg;

    logic [RCP_PW-1:0]   rcp_x, rcp_y;
    logic [PROD_W-1:0]   quo_x, quo_y;
    logic [SAMPLE_W-1:0] den_x, den_y;
    logic                done_x, done_y;
    logic [SAMPLE_W-1:0] lo_x, lo_y, cl_x, cl_y;
    logic                zero_span_x, zero_span_y;

    // accumulators and run counter
    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        cnt_next   = cnt_reg;
        if (cmd.clear_up || cmd.load_fin)
        begin
            sum_x_next = '0;
            sum_y_next = '0;
            cnt_next   = '0;
        end
        else if (cmd.accum)
        begin
            sum_x_next = sum_x_reg + SUM_W'(sample_x);
            sum_y_next = sum_y_reg + SUM_W'(sample_y);
            cnt_next   = status.last ? '0 : cnt_reg + 1'b1;
        end
    end

    assign status.last     = (cnt_reg == CNT_W'(SAMPLES - 1));
    assign status.div_done = done_x && done_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            cnt_reg   <= cnt_next;
        end
    end

    // averages and divider operands for the scaling
    always_comb
    begin
        rcp_x = RCP_PW'(sum_x_reg) * RCP_PW'(RCP_MUL);
        rcp_y = RCP_PW'(sum_y_reg) * RCP_PW'(RCP_MUL);
        den_x = raw_x_max - raw_x_min;
        den_y = raw_y_max - raw_y_min;
    end

    tsas_div #(
        .NUM_W (PROD_W),
        .DEN_W (SAMPLE_W)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (prod_x_reg),
        .den   (den_x),
        .done  (done_x),
        .quo   (quo_x)
    );

    tsas_div #(
        .NUM_W (PROD_W),
        .DEN_W (SAMPLE_W)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (prod_y_reg),
        .den   (den_y),
        .done  (done_y),
        .quo   (quo_y)
    );

    // raise to min, then lower to max
    always_comb
    begin
        lo_x  = (avg_x_reg < raw_x_min) ? raw_x_min : avg_x_reg;
        lo_y  = (avg_y_reg < raw_y_min) ? raw_y_min : avg_y_reg;
        cl_x  = (lo_x > raw_x_max) ? raw_x_max : lo_x;
        cl_y  = (lo_y > raw_y_max) ? raw_y_max : lo_y;
        zero_span_x = (raw_x_max <= raw_x_min);
        zero_span_y = (raw_y_max <= raw_y_min);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_avg)
        begin
            avg_x_reg <= rcp_x[RCP_SH +: SAMPLE_W];
            avg_y_reg <= rcp_y[RCP_SH +: SAMPLE_W];
        end
        if (cmd.cap_avg)
        begin
            diff_x_reg <= cl_x - raw_x_min;
            diff_y_reg <= cl_y - raw_y_min;
        end
        if (cmd.mul)
        begin
            prod_x_reg <= PROD_W'(diff_x_reg) * PROD_W'(screen_width);
            prod_y_reg <= PROD_W'(diff_y_reg) * PROD_W'(screen_height);
        end
        if (cmd.clear_up)
        begin
            touched_reg <= 1'b0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
        end
        else if (cmd.load_fin)
        begin
            touched_reg <= 1'b1;
            pos_x_reg   <= zero_span_x ? '0 : quo_x[POS_W-1:0];
            pos_y_reg   <= zero_span_y ? '0 : quo_y[POS_W-1:0];
        end
    end

    assign touched = touched_reg;
    assign pos_x   = pos_x_reg;
    assign pos_y   = pos_y_reg;

endmodule

@@ rtl/core/tsas_ctrl.sv @@
// sequencing state machine and output valid for the touch averaging block
module tsas_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   pen_down,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tsas_pkg::tsas_cmd_t    cmd,
    input  tsas_pkg::tsas_status_t status
);

    import tsas_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_AVG       = 3'd1;
    localparam logic [2:0] ST_CLAMP     = 3'd2;
    localparam logic [2:0] ST_MUL       = 3'd3;
    localparam logic [2:0] ST_SCL_START = 3'd4;
    localparam logic [2:0] ST_SCL_WAIT  = 3'd5;
    localparam logic [2:0] ST_FIN       = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       in_take;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        in_ready = (state_reg == ST_IDLE) && out_free;
        in_take  = in_valid && in_ready;

        cmd            = '0;
        cmd.accum      = in_take && pen_down;
        cmd.clear_up   = in_take && !pen_down;
        state_next     = state_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && pen_down && status.last)
                begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                cmd.div_avg = 1'b1;
                state_next  = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.cap_avg = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SCL_START;
            end
            ST_SCL_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_SCL_WAIT;
            end
            ST_SCL_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // quotient holds in the divider until the output slot frees
                if (out_free)
                begin
                    cmd.load_fin = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_fin || cmd.clear_up)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/touch_sample_average_scale.sv @@
// top level: calibration registers, controller and datapath of the touch averaging block
//
// channel   direction  handshake               payload
// input     in         in_valid / in_ready     pen_down, sample_x, sample_y
// output    out        out_valid / out_ready   touched, pos_x, pos_y
// config    in         psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// an item that only adds to the run is taken without holding the input off; a pen-up item
// is taken the same way and loads its result at once. the item that completes a run holds
// the input off while the block averages, clamps, multiplies, starts the divider, waits on the
// bit-serial divider lanes that form the scaled coordinate, and loads the result.
// reset clears the run and the output valid and restores the calibration registers.
// input ready drops while a run is being computed or a result waits unread.
module touch_sample_average_scale #(
    parameter int SAMPLES = tsas_pkg::SAMPLES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          pen_down,
    input  logic [tsas_pkg::SAMPLE_W-1:0] sample_x,
    input  logic [tsas_pkg::SAMPLE_W-1:0] sample_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          touched,
    output logic [tsas_pkg::POS_W-1:0]    pos_x,
    output logic [tsas_pkg::POS_W-1:0]    pos_y,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsas_pkg::ADDR_W-1:0]   paddr,
    input  logic [tsas_pkg::DATA_W-1:0]   pwdata,
    output logic [tsas_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    import tsas_pkg::*;

    logic [SAMPLE_W-1:0]  raw_x_min_reg, raw_x_max_reg, raw_y_min_reg, raw_y_max_reg;
    logic [POS_W-1:0]     screen_width_reg, screen_height_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    tsas_cmd_t            cmd;
    tsas_status_t         status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_x_min_reg     <= RAW_MIN_RESET;
            raw_x_max_reg     <= RAW_MAX_RESET;
            raw_y_min_reg     <= RAW_MIN_RESET;
            raw_y_max_reg     <= RAW_MAX_RESET;
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_RAW_X_MIN:     raw_x_min_reg     <= pwdata[SAMPLE_W-1:0];
                REG_RAW_X_MAX:     raw_x_max_reg     <= pwdata[SAMPLE_W-1:0];
                REG_RAW_Y_MIN:     raw_y_min_reg     <= pwdata[SAMPLE_W-1:0];
                REG_RAW_Y_MAX:     raw_y_max_reg     <= pwdata[SAMPLE_W-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[POS_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[POS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RAW_X_MIN:     prdata = DATA_W'(raw_x_min_reg);
            REG_RAW_X_MAX:     prdata = DATA_W'(raw_x_max_reg);
            REG_RAW_Y_MIN:     prdata = DATA_W'(raw_y_min_reg);
            REG_RAW_Y_MAX:     prdata = DATA_W'(raw_y_max_reg);
            REG_SCREEN_WIDTH:  prdata = DATA_W'(screen_width_reg);
            REG_SCREEN_HEIGHT: prdata = DATA_W'(screen_height_reg);
            default:           prdata = '0;
        endcase
    end

    tsas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pen_down  (pen_down),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tsas_datapath #(
        .SAMPLES (SAMPLES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample_x      (sample_x),
        .sample_y      (sample_y),
        .raw_x_min     (raw_x_min_reg),
        .raw_x_max     (raw_x_max_reg),
        .raw_y_min     (raw_y_min_reg),
        .raw_y_max     (raw_y_max_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .touched       (touched),
        .pos_x         (pos_x),
        .pos_y         (pos_y)
    );

endmodule
